>>> rtl/core/lru_key_value_cache_defines.svh
// Assertion macros for the LRU key/value cache RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset
`define LKVC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked out of reset
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LKVC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/lkvc_pkg.sv
// Shared constants for the LRU key/value cache.
// No dependencies; imported by lru_key_value_cache and its testbench.
package lkvc_pkg;

	// Capacity register
	localparam int unsigned CAP_BITS = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	// Action codes
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

endpackage

>>> rtl/core/lru_key_value_cache.sv
// LRU key/value cache: one get or put per transfer, one result per item. Each item passes
// through the scan, drain, resolve and finish states before the next input transfer: one
// key comparator walks the key memory one entry per cycle in the scan state, the drain state
// compares the last entry read, the resolve state picks the hit, victim or free slot and
// updates the recency ranks, the finish state loads the result register, and the block is
// then idle and takes the next transfer. The input stalls while an item is in flight, and
// for longer while a finished result waits for a full, stalled output register; a finished
// result may wait in the output register while the next item is taken. The capacity
// register is written only while idle.
// Depends on lkvc_pkg and lru_key_value_cache_defines.svh.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache
	import lkvc_pkg::*;
#(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// capacity register write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CAP_BITS-1:0]   capacity_in_use,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic [KEY_BITS-1:0]   lookup_key,
	input  logic [VALUE_BITS-1:0] new_value,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic [VALUE_BITS-1:0] read_value,
	output logic                  evicted
);

	localparam int IDX_BITS  = $clog2(ENTRIES);
	localparam int RANK_BITS = $clog2(ENTRIES);
	localparam int OCC_BITS  = $clog2(ENTRIES + 1);

	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN    = 3'd1;
	localparam logic [2:0] ST_DRAIN   = 3'd2;
	localparam logic [2:0] ST_RESOLVE = 3'd3;
	localparam logic [2:0] ST_FINISH  = 3'd4;

	logic [2:0]            state_q;
	logic [CAP_BITS-1:0]   cap_q;
	logic [OCC_BITS-1:0]   occ_q;
	logic [ENTRIES-1:0]    valid_q;
	logic [RANK_BITS-1:0]  rank_q [ENTRIES];

	logic [KEY_BITS-1:0]   key_mem [ENTRIES];
	logic [VALUE_BITS-1:0] val_mem [ENTRIES];

	// latched request
	logic                  act_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	// scan pipeline
	logic [IDX_BITS-1:0]   rd_idx_q;
	logic                  cmp_vld_s1;
	logic [IDX_BITS-1:0]   idx_s1;
	logic [KEY_BITS-1:0]   key_rd_s1;

	// scan results
	logic                  found_q;
	logic [IDX_BITS-1:0]   found_idx_q;
	logic [RANK_BITS-1:0]  found_rank_q;
	logic                  free_found_q;
	logic [IDX_BITS-1:0]   free_idx_q;
	logic                  vict_any_q;
	logic [IDX_BITS-1:0]   vict_idx_q;
	logic [RANK_BITS-1:0]  vict_rank_q;

	// resolved outcome
	logic                  res_hit_q;
	logic                  res_ev_q;
	logic                  res_rd_q;
	logic [VALUE_BITS-1:0] val_rd_q;

	// output register
	logic                  out_valid_q;
	logic                  hit_q;
	logic                  evicted_q;
	logic [VALUE_BITS-1:0] read_value_q;

	logic                  in_xfer;
	logic                  out_load;
	logic [OCC_BITS-1:0]   cap_eff;
	logic                  is_put;
	logic                  cmp_v;
	logic [RANK_BITS-1:0]  cmp_r;

	// resolve decisions
	logic                  upd_en;
	logic                  upd_all;
	logic [IDX_BITS-1:0]   upd_slot;
	logic [RANK_BITS-1:0]  upd_old;
	logic                  wr_key;
	logic                  wr_val;
	logic                  set_valid;
	logic                  do_evict;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign cfg_ready  = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign evicted    = evicted_q;
	assign read_value = read_value_q;
	assign out_load   = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign is_put     = (act_q == ACT_PUT);

	// Clamp the capacity to 1..ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = OCC_BITS'(1);
		end else if (32'(cap_q) > ENTRIES) begin
			cap_eff = OCC_BITS'(ENTRIES);
		end else begin
			cap_eff = OCC_BITS'(cap_q);
		end
	end

	assign cmp_v = valid_q[idx_s1];
	assign cmp_r = rank_q[idx_s1];

	// Pick the slot to touch once the scan is done
	always_comb begin
		upd_en    = 1'b0;
		upd_all   = 1'b0;
		upd_slot  = found_idx_q;
		upd_old   = found_rank_q;
		wr_key    = 1'b0;
		wr_val    = 1'b0;
		set_valid = 1'b0;
		do_evict  = 1'b0;
		if (state_q == ST_RESOLVE) begin
			if (found_q) begin
				upd_en = 1'b1;
				wr_val = is_put;
			end else if (is_put && (occ_q >= cap_eff)) begin
				if (vict_any_q) begin
					upd_en   = 1'b1;
					upd_slot = vict_idx_q;
					upd_old  = vict_rank_q;
					wr_key   = 1'b1;
					wr_val   = 1'b1;
					do_evict = 1'b1;
				end
			end else if (is_put && free_found_q) begin
				upd_en    = 1'b1;
				upd_all   = 1'b1;
				upd_slot  = free_idx_q;
				wr_key    = 1'b1;
				wr_val    = 1'b1;
				set_valid = 1'b1;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q  <= ST_SCAN;
						rd_idx_q <= '0;
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= 1'b1;
					if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					cmp_vld_s1 <= 1'b0;
					state_q    <= ST_RESOLVE;
				end
				ST_RESOLVE: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					cmp_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Latch the request and advance the scan read stage
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			act_q <= action;
			key_q <= lookup_key;
			val_q <= new_value;
		end
		if (state_q == ST_SCAN) begin
			key_rd_s1 <= key_mem[rd_idx_q];
			idx_s1    <= rd_idx_q;
		end
	end

	// Shared key comparator plus free-slot and oldest-entry tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			vict_any_q   <= 1'b0;
		end else if (in_xfer) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			vict_any_q   <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (cmp_v && (key_rd_s1 == key_q) && !found_q) begin
				found_q <= 1'b1;
			end
			if (!cmp_v && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (cmp_v && (!vict_any_q || (cmp_r > vict_rank_q))) begin
				vict_any_q <= 1'b1;
			end
		end
	end

	// Payload of the scan results
	always_ff @(posedge clk) begin
		if (cmp_vld_s1) begin
			if (cmp_v && (key_rd_s1 == key_q) && !found_q) begin
				found_idx_q  <= idx_s1;
				found_rank_q <= cmp_r;
			end
			if (!cmp_v && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (cmp_v && (!vict_any_q || (cmp_r > vict_rank_q))) begin
				vict_idx_q  <= idx_s1;
				vict_rank_q <= cmp_r;
			end
		end
	end

	// Key memory: read during the scan, written on insert
	always_ff @(posedge clk) begin
		if (wr_key) begin
			key_mem[upd_slot] <= key_q;
		end
	end

	// Value memory: read and written while resolving
	always_ff @(posedge clk) begin
		if (state_q == ST_RESOLVE) begin
			val_rd_q <= val_mem[found_idx_q];
		end
		if (wr_val) begin
			val_mem[upd_slot] <= val_q;
		end
	end

	// Valid bits, occupancy and capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= capacity_in_use;
			end
			if (set_valid) begin
				valid_q[upd_slot] <= 1'b1;
				occ_q             <= occ_q + 1'b1;
			end
		end
	end

	// Recency ranks: touched slot goes to zero, younger entries age by one
	for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_rank
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rank_q[gi] <= '0;
			end else if (upd_en) begin
				if (upd_slot == IDX_BITS'(gi)) begin
					rank_q[gi] <= '0;
				end else if (valid_q[gi] && (upd_all || (rank_q[gi] < upd_old))) begin
					rank_q[gi] <= rank_q[gi] + 1'b1;
				end
			end
		end
	end

	// Register the outcome
	always_ff @(posedge clk) begin
		if (state_q == ST_RESOLVE) begin
			res_hit_q <= found_q;
			res_ev_q  <= do_evict;
			res_rd_q  <= found_q && !is_put;
		end
	end

	// Output register: hold until the result transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q        <= res_hit_q;
			evicted_q    <= res_ev_q;
			read_value_q <= res_rd_q ? val_rd_q : '0;
		end
	end

	// Checks
	`LKVC_ASSERT_IMPL(a_occ_matches_valid, clk, arst_n, 1'b1, $countones(valid_q) == 32'(occ_q), "occupancy differs from valid count")
	`LKVC_ASSERT_IMPL(a_hit_no_evict, clk, arst_n, out_valid_q, !(hit_q && evicted_q), "eviction reported on a hit")
	`LKVC_ASSERT_IMPL(a_value_needs_hit, clk, arst_n, out_valid_q && (read_value_q != '0), hit_q && !evicted_q, "read value without get hit")
	`LKVC_ASSERT_NEXT(a_accept_starts_scan, clk, arst_n, in_xfer, (state_q == ST_SCAN) && (rd_idx_q == '0), "accepted item did not start a scan")

endmodule

>>> bench/lru_key_value_cache_tb.sv
// Self-checking testbench for lru_key_value_cache: a get/put stream is checked against an
// in-bench LRU predictor, under random idling, stalls and capacity changes.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 100ps

module lru_key_value_cache_tb;
	import lkvc_pkg::*;

	localparam int SLOTS = 16;
	localparam int KEY_W = 16;
	localparam int VAL_W = 31;
	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
	localparam int RX_HOLD_LEN = 250;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic             act;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} cache_req_t;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
	} cache_result_t;

	// DUT ports
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CAP_BITS-1:0] capacity_in_use = CAP_RESET;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                action = ACT_GET;
	logic [KEY_W-1:0]    lookup_key = '0;
	logic [VAL_W-1:0]    new_value = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                hit;
	logic [VAL_W-1:0]    read_value;
	logic                evicted;

	// Predicted cache contents
	logic [KEY_W-1:0]    model_key [SLOTS];
	logic [VAL_W-1:0]    model_value [SLOTS];
	bit                  model_valid [SLOTS] = '{default: 1'b0};
	int unsigned         model_rank [SLOTS] = '{default: 0};
	int unsigned         model_occ = 0;
	logic [CAP_BITS-1:0] model_cap = CAP_RESET;

	// Request queue and expected results
	cache_req_t          pending_reqs[$];
	cache_req_t          req_on_bus;
	cache_result_t       expected_results[$];
	cache_result_t       exp_res;
	cache_result_t       got_res;
	int                  err_count = 0;

	// Idling controls
	bit                  tx_idle_on = 1'b1;
	bit                  rx_idle_on = 1'b1;
	int                  tx_gap_left = 0;
	int                  rx_gap_left = 0;
	int                  rx_hold_req_count = 0;
	int                  rx_hold_served = 0;
	int                  rx_hold_left = 0;
	logic                rx_hold_active = 1'b0;

	lru_key_value_cache #(
		.ENTRIES(SLOTS),
		.KEY_BITS(KEY_W),
		.VALUE_BITS(VAL_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.capacity_in_use(capacity_in_use),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.lookup_key(lookup_key),
		.new_value(new_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.read_value(read_value),
		.evicted(evicted)
	);

	always #5 clk = ~clk;

	// Age every valid entry younger than slot s, then make s the most recent
	function automatic void make_most_recent(int s, int unsigned old_rank);
		for (int i = 0; i < SLOTS; i++) begin
			if (model_valid[i] && i != s && model_rank[i] < old_rank)
				model_rank[i]++;
		end
		model_rank[s] = 0;
	endfunction

	// Apply one access to the predicted contents and return its result
	function automatic cache_result_t predict_access(cache_req_t req);
		int            found;
		int            victim;
		int            slot;
		int unsigned   cap;
		int unsigned   oldest;
		cache_result_t res;
		res = '0;
		found = -1;
		victim = -1;
		slot = -1;
		oldest = 0;
		cap = 32'(model_cap);
		if (cap == 0)
			cap = 1;
		else if (cap > SLOTS)
			cap = SLOTS;
		for (int i = 0; i < SLOTS; i++) begin
			if (found < 0 && model_valid[i] && model_key[i] == req.key)
				found = i;
		end
		if (found >= 0) begin
			res.hit = 1'b1;
			if (req.act == ACT_GET)
				res.read_value = model_value[found];
			else
				model_value[found] = req.value;
			make_most_recent(found, model_rank[found]);
		end else if (req.act == ACT_PUT) begin
			if (model_occ >= cap) begin
				// evict the least recent entry and reuse its slot
				for (int i = 0; i < SLOTS; i++) begin
					if (model_valid[i] && (victim < 0 || model_rank[i] > oldest)) begin
						oldest = model_rank[i];
						victim = i;
					end
				end
				if (victim >= 0) begin
					res.evicted = 1'b1;
					model_key[victim] = req.key;
					model_value[victim] = req.value;
					make_most_recent(victim, oldest);
				end
			end else begin
				// insert into the lowest free slot
				for (int i = 0; i < SLOTS; i++) begin
					if (slot < 0 && !model_valid[i])
						slot = i;
				end
				if (slot >= 0) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (model_valid[i])
							model_rank[i]++;
					end
					model_valid[slot] = 1'b1;
					model_key[slot] = req.key;
					model_value[slot] = req.value;
					model_rank[slot] = 0;
					model_occ++;
				end
			end
		end
		return res;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap(bit enable);
		int r;
		if (!enable)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void note_error(string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	task automatic add_req(logic act, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
		cache_req_t req;
		req.act = act;
		req.key = key;
		req.value = value;
		pending_reqs.push_back(req);
	endtask

	// Wait until every request is sent and every result has come back
	task automatic wait_drained();
		@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write the capacity register; call only while idle
	task automatic write_capacity(logic [CAP_BITS-1:0] cap);
		@(posedge clk);
		cfg_valid <= 1'b1;
		capacity_in_use <= cap;
		do @(posedge clk); while (!cfg_ready);
		model_cap = cap;
		cfg_valid <= 1'b0;
	endtask

	// Queue random accesses, keys mostly drawn from a small working set
	task automatic queue_random(int count);
		logic [KEY_W-1:0] key_pool [20];
		int               pool_size;
		int               r;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		pool_size = ($urandom_range(0, 2) == 0) ? 4 : 20;
		for (int i = 0; i < 20; i++)
			key_pool[i] = KEY_W'($urandom_range(0, 65535));
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 4) == 0)
				key = KEY_W'($urandom_range(0, 65535));
			else
				key = key_pool[$urandom_range(0, pool_size - 1)];
			r = $urandom_range(0, 9);
			if (r == 0)
				value = '0;
			else if (r == 1)
				value = VAL_MAX;
			else
				value = VAL_W'($urandom());
			add_req($urandom_range(0, 1) ? ACT_PUT : ACT_GET, key, value);
		end
	endtask

	task automatic set_idling(bit tx_on, bit rx_on);
		@(negedge clk);
		tx_idle_on = tx_on;
		rx_idle_on = rx_on;
	endtask

	// Request driver: predict on each transfer, then present the next request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_GET;
			lookup_key <= '0;
			new_value <= '0;
			tx_gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(predict_access(req_on_bus));
			if (!in_valid || !in_stall) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					req_on_bus = pending_reqs.pop_front();
					action <= req_on_bus.act;
					lookup_key <= req_on_bus.key;
					new_value <= req_on_bus.value;
					in_valid <= 1'b1;
					tx_gap_left = pick_gap(tx_idle_on);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold_left <= 0;
			rx_hold_active <= 1'b0;
		end else if (rx_hold_req_count != rx_hold_served) begin
			rx_hold_served <= rx_hold_req_count;
			rx_hold_left <= RX_HOLD_LEN;
			rx_hold_active <= 1'b1;
		end else if (rx_hold_left > 1) begin
			rx_hold_left <= rx_hold_left - 1;
		end else begin
			rx_hold_left <= 0;
			rx_hold_active <= 1'b0;
		end
	end

	// Result monitor: check each transfer against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_gap_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got_res.hit = hit;
				got_res.read_value = read_value;
				got_res.evicted = evicted;
				if (expected_results.size() == 0) begin
					note_error($sformatf("result with nothing expected: hit=%0b value=%0h evicted=%0b",
						hit, read_value, evicted));
				end else begin
					exp_res = expected_results.pop_front();
					if (got_res.hit !== exp_res.hit || got_res.read_value !== exp_res.read_value ||
							got_res.evicted !== exp_res.evicted)
						note_error($sformatf(
							"mismatch: hit exp %0b got %0b, value exp %0h got %0h, evicted exp %0b got %0b",
							exp_res.hit, got_res.hit, exp_res.read_value, got_res.read_value,
							exp_res.evicted, got_res.evicted));
				end
			end
			if (rx_gap_left > 0)
				rx_gap_left--;
			else if ($urandom_range(0, 3) == 0)
				rx_gap_left = pick_gap(rx_idle_on);
			out_stall <= rx_hold_active || (rx_gap_left != 0);
		end
	end

	// Stimulus sequence
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: empty miss, field extremes, update, fill to capacity, evictions
		add_req(ACT_GET, 16'h0000, '0);
		add_req(ACT_PUT, 16'h0000, '0);
		add_req(ACT_PUT, 16'hFFFF, VAL_MAX);
		add_req(ACT_GET, 16'hFFFF, '0);
		add_req(ACT_GET, 16'h0000, VAL_MAX);
		add_req(ACT_PUT, 16'h0000, 31'h2AAAAAAA);
		add_req(ACT_GET, 16'h0000, '0);
		add_req(ACT_PUT, 16'hAAAA, 31'h55555555);
		add_req(ACT_PUT, 16'h5555, 31'h2AAAAAAA);
		for (int k = 1; k <= 12; k++)
			add_req(ACT_PUT, KEY_W'(k), VAL_W'(k * 3));
		add_req(ACT_PUT, 16'h1234, 31'h1234);
		add_req(ACT_GET, 16'hFFFF, '0);
		add_req(ACT_GET, 16'h0000, '0);
		add_req(ACT_PUT, 16'h4321, 31'h4321);
		wait_drained();

		// Capacity lowered below occupancy
		write_capacity(5'd3);
		queue_random(60);
		wait_drained();

		// Zero capacity acts as one
		write_capacity(5'd0);
		queue_random(40);
		wait_drained();

		// Capacity above the entry count, no idling on either side
		write_capacity(5'd31);
		set_idling(1'b0, 1'b0);
		queue_random(60);
		wait_drained();
		set_idling(1'b1, 1'b1);

		write_capacity(5'd1);
		queue_random(40);
		wait_drained();

		// Hold the receiver off while the sender keeps offering
		write_capacity(5'd16);
		set_idling(1'b0, 1'b1);
		rx_hold_req_count++;
		queue_random(60);
		wait_drained();
		set_idling(1'b1, 1'b1);

		// Pause the sender until every result is back
		write_capacity(CAP_BITS'($urandom_range(2, 15)));
		queue_random(35);
		wait_drained();
		queue_random(35);
		wait_drained();

		write_capacity(CAP_BITS'($urandom_range(0, 31)));
		queue_random(70);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			note_error($sformatf("%0d results never arrived", expected_results.size()));
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Stop a hung run
	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lkvc_pkg.sv
rtl/core/lru_key_value_cache.sv
bench/lru_key_value_cache_tb.sv
